[hdl/tiem_pkg.sv]
// Shared types and constants of the time interval error meter.
`default_nettype none
package tiem_pkg;

  localparam int TIME_BITS_DEF = 62;

  typedef enum logic [1:0] {
    FUNC_CLOCK  = 2'd0,
    FUNC_GOLDEN = 2'd1,
    FUNC_END    = 2'd2
  } func_t;

  typedef struct packed {
    logic emit;
    logic is_final;
  } tiem_step_t;

endpackage
`default_nettype wire

[hdl/tiem_in_reg.sv]
// Input register of the time interval error meter.
`default_nettype none
module tiem_in_reg #(
  parameter int TIME_BITS = tiem_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_func,
  input  wire logic [TIME_BITS-1:0] in_edge_time,
  input  wire logic                 advance,
  output logic                      item_valid,
  output logic [1:0]                item_func,
  output logic [TIME_BITS-1:0]      item_time
);

  logic                 valid_r;
  logic                 valid_nxt;
  logic [1:0]           func_r;
  logic [TIME_BITS-1:0] time_r;

  assign in_stall  = valid_r && !advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      func_r <= in_func;
      time_r <= in_edge_time;
    end
  end

  assign item_valid = valid_r;
  assign item_func  = func_r;
  assign item_time  = time_r;

endmodule
`default_nettype wire

[hdl/tiem_core.sv]
// Interval state and sample arithmetic of the time interval error meter.
`default_nettype none
module tiem_core #(
  parameter int TIME_BITS = tiem_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [TIME_BITS-1:0] cfg_holdoff,
  input  wire logic                 item_valid,
  input  wire logic [1:0]           item_func,
  input  wire logic [TIME_BITS-1:0] item_time,
  input  wire logic                 advance,
  output tiem_pkg::tiem_step_t      step,
  output logic [TIME_BITS-1:0]      res_sample_time,
  output logic [TIME_BITS:0]        res_interval_error,
  output logic [TIME_BITS-1:0]      res_sample_duration
);

  logic [TIME_BITS-1:0] skip_r;
  logic [TIME_BITS-1:0] last_golden_r;
  logic [TIME_BITS-1:0] last_golden_nxt;
  logic                 golden_seen_r;
  logic                 golden_seen_nxt;
  logic [TIME_BITS-1:0] pending_r;
  logic [TIME_BITS-1:0] pending_nxt;
  logic                 pending_valid_r;
  logic                 pending_valid_nxt;
  logic [TIME_BITS-1:0] held_mid_r;
  logic [TIME_BITS-1:0] held_mid_nxt;
  logic [TIME_BITS-1:0] held_clk_r;
  logic [TIME_BITS-1:0] held_clk_nxt;
  logic                 held_valid_r;
  logic                 held_valid_nxt;

  logic                 fire;
  logic [TIME_BITS-1:0] delta;
  logic [TIME_BITS-1:0] mid;
  logic                 measured;

  assign fire     = item_valid && advance;
  assign delta    = item_time - last_golden_r;
  assign mid      = last_golden_r + {1'b0, delta[TIME_BITS-1:1]};
  assign measured = golden_seen_r && pending_valid_r && (pending_r < item_time);

  always_comb begin
    last_golden_nxt   = last_golden_r;
    golden_seen_nxt   = golden_seen_r;
    pending_nxt       = pending_r;
    pending_valid_nxt = pending_valid_r;
    held_mid_nxt      = held_mid_r;
    held_clk_nxt      = held_clk_r;
    held_valid_nxt    = held_valid_r;
    step              = '0;
    res_sample_time     = held_mid_r;
    res_interval_error  = {1'b0, held_clk_r} - {1'b0, held_mid_r};
    res_sample_duration = pending_r - held_mid_r;
    if (fire) begin
      case (item_func)
        tiem_pkg::FUNC_CLOCK: begin
          if (golden_seen_r && !pending_valid_r && (item_time > last_golden_r)) begin
            pending_nxt       = item_time;
            pending_valid_nxt = 1'b1;
          end
        end
        tiem_pkg::FUNC_GOLDEN: begin
          if (measured && (last_golden_r >= skip_r)) begin
            step.emit      = held_valid_r;
            held_mid_nxt   = mid;
            held_clk_nxt   = pending_r;
            held_valid_nxt = 1'b1;
          end
          last_golden_nxt   = item_time;
          golden_seen_nxt   = 1'b1;
          pending_valid_nxt = 1'b0;
        end
        tiem_pkg::FUNC_END: begin
          step.emit           = held_valid_r;
          step.is_final       = 1'b1;
          res_sample_duration = {{(TIME_BITS-1){1'b0}}, 1'b1};
          golden_seen_nxt     = 1'b0;
          pending_valid_nxt   = 1'b0;
          held_valid_nxt      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r          <= '0;
      golden_seen_r   <= 1'b0;
      pending_valid_r <= 1'b0;
      held_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        skip_r <= cfg_holdoff;
      end
      golden_seen_r   <= golden_seen_nxt;
      pending_valid_r <= pending_valid_nxt;
      held_valid_r    <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_golden_r <= last_golden_nxt;
    pending_r     <= pending_nxt;
    held_mid_r    <= held_mid_nxt;
    held_clk_r    <= held_clk_nxt;
  end

`ifndef NO_ASSERTIONS
  a_pending_needs_golden: assert property (@(posedge clk) disable iff (!rst_n)
    pending_valid_r |-> golden_seen_r)
    else $error("Pending clock edge without a golden edge.");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item_func == tiem_pkg::FUNC_END) |=> (!held_valid_r && !golden_seen_r))
    else $error("End of capture did not clear the state.");

  a_clock_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item_func == tiem_pkg::FUNC_CLOCK) |-> !step.emit)
    else $error("A clock edge produced a sample.");

  a_final_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    step.is_final |-> (fire && item_func == tiem_pkg::FUNC_END))
    else $error("Final flag raised outside end of capture.");
`endif

endmodule
`default_nettype wire

[hdl/tiem_out_reg.sv]
// Result register of the time interval error meter.
`default_nettype none
module tiem_out_reg #(
  parameter int TIME_BITS = tiem_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tiem_pkg::tiem_step_t step,
  input  wire logic [TIME_BITS-1:0] res_sample_time,
  input  wire logic [TIME_BITS:0]   res_interval_error,
  input  wire logic [TIME_BITS-1:0] res_sample_duration,
  output logic                      advance,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [TIME_BITS-1:0]      out_sample_time,
  output logic [TIME_BITS:0]        out_interval_error,
  output logic [TIME_BITS-1:0]      out_sample_duration,
  output logic                      out_is_final
);

  logic                 valid_r;
  logic                 valid_nxt;
  logic [TIME_BITS-1:0] time_r;
  logic [TIME_BITS:0]   error_r;
  logic [TIME_BITS-1:0] duration_r;
  logic                 final_r;

  assign advance   = !valid_r || !out_stall;
  assign valid_nxt = advance ? step.emit : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      time_r     <= res_sample_time;
      error_r    <= res_interval_error;
      duration_r <= res_sample_duration;
      final_r    <= step.is_final;
    end
  end

  assign out_valid           = valid_r;
  assign out_sample_time     = time_r;
  assign out_interval_error  = error_r;
  assign out_sample_duration = duration_r;
  assign out_is_final        = final_r;

endmodule
`default_nettype wire

[hdl/time_interval_error_meter_unit.sv]
// Top level of the time interval error meter.
//
// The input channel carries a time-ordered stream of edges: in_func selects a
// clock edge, a golden reference edge or the end-of-capture mark, and
// in_edge_time gives the timestamp. A transfer takes place when in_valid is
// high and in_stall is low; one item can be taken in every cycle.
// Each golden edge that closes an interval holding a clock edge may release the
// previously measured sample on the output channel, with its midpoint, its
// interval error and its duration. End of capture releases the held sample
// marked final and clears the measurement state.
// An item is evaluated while it sits in the input register, and a result that
// it releases is loaded into the output register. The output register holds a
// result while out_stall is high; the input register then fills and in_stall
// rises, so nothing is lost. The hold-off time, before which reference
// intervals give no sample, is written through cfg_valid and cfg_holdoff; the
// user must write it only while idle, as the block itself does not enforce
// this. cfg_ready is always high. Synchronous reset clears all valid flags and
// sets the hold-off time to zero.
`default_nettype none
module time_interval_error_meter_unit #(
  parameter int TIME_BITS = tiem_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [TIME_BITS-1:0] cfg_holdoff,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_func,
  input  wire logic [TIME_BITS-1:0] in_edge_time,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [TIME_BITS-1:0]      out_sample_time,
  output logic [TIME_BITS:0]        out_interval_error,
  output logic [TIME_BITS-1:0]      out_sample_duration,
  output logic                      out_is_final
);

  logic                 advance;
  logic                 item_valid;
  logic [1:0]           item_func;
  logic [TIME_BITS-1:0] item_time;
  tiem_pkg::tiem_step_t step;
  logic [TIME_BITS-1:0] res_sample_time;
  logic [TIME_BITS:0]   res_interval_error;
  logic [TIME_BITS-1:0] res_sample_duration;

  assign cfg_ready = 1'b1;

  tiem_in_reg #(.TIME_BITS(TIME_BITS)) u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_edge_time (in_edge_time),
    .advance      (advance),
    .item_valid   (item_valid),
    .item_func    (item_func),
    .item_time    (item_time)
  );

  tiem_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_holdoff         (cfg_holdoff),
    .item_valid          (item_valid),
    .item_func           (item_func),
    .item_time           (item_time),
    .advance             (advance),
    .step                (step),
    .res_sample_time     (res_sample_time),
    .res_interval_error  (res_interval_error),
    .res_sample_duration (res_sample_duration)
  );

  tiem_out_reg #(.TIME_BITS(TIME_BITS)) u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .step                (step),
    .res_sample_time     (res_sample_time),
    .res_interval_error  (res_interval_error),
    .res_sample_duration (res_sample_duration),
    .advance             (advance),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sample_time     (out_sample_time),
    .out_interval_error  (out_interval_error),
    .out_sample_duration (out_sample_duration),
    .out_is_final        (out_is_final)
  );

endmodule
`default_nettype wire

[tb/sv/tiem_scoreboard_pkg.sv]
// Scoreboard class that predicts and checks the samples of the time interval error meter.
`timescale 1ns / 100ps
package tiem_scoreboard_pkg;

  typedef logic [tiem_pkg::TIME_BITS_DEF-1:0] stamp_t;
  typedef logic [tiem_pkg::TIME_BITS_DEF:0]   err_t;

  typedef struct {
    stamp_t sample_time;
    err_t   interval_error;
    stamp_t sample_duration;
    logic   is_final;
  } tie_sample_t;

  class tie_scoreboard;
    tie_sample_t awaited_samples[$];
    stamp_t      holdoff;
    stamp_t      last_golden;
    bit          golden_seen;
    stamp_t      pending_clk;
    bit          pending_valid;
    stamp_t      held_mid;
    err_t        held_err;
    bit          held_valid;
    int unsigned errors;

    function new();
      holdoff = '0;
      errors = 0;
      clear_capture();
    endfunction

    function void clear_capture();
      last_golden = '0;
      golden_seen = 1'b0;
      pending_clk = '0;
      pending_valid = 1'b0;
      held_mid = '0;
      held_err = '0;
      held_valid = 1'b0;
    endfunction

    function void set_holdoff(stamp_t value);
      holdoff = value;
    endfunction

    function void apply_edge(logic [1:0] func, stamp_t t);
      stamp_t      mid;
      stamp_t      dur;
      tie_sample_t s;
      case (func)
        tiem_pkg::FUNC_CLOCK: begin
          if (golden_seen && !pending_valid && t > last_golden) begin
            pending_clk = t;
            pending_valid = 1'b1;
          end
        end
        tiem_pkg::FUNC_GOLDEN: begin
          if (golden_seen && pending_valid && pending_clk < t) begin
            mid = t - last_golden;
            mid = last_golden + (mid >> 1);
            if (last_golden >= holdoff) begin
              if (held_valid) begin
                dur = pending_clk - held_mid;
                s = '{held_mid, held_err, dur, 1'b0};
                awaited_samples.push_back(s);
              end
              held_mid = mid;
              held_err = {1'b0, pending_clk} - {1'b0, mid};
              held_valid = 1'b1;
            end
          end
          last_golden = t;
          golden_seen = 1'b1;
          pending_clk = '0;
          pending_valid = 1'b0;
        end
        tiem_pkg::FUNC_END: begin
          if (held_valid) begin
            dur = stamp_t'(1);
            s = '{held_mid, held_err, dur, 1'b1};
            awaited_samples.push_back(s);
          end
          clear_capture();
        end
        default: ;
      endcase
    endfunction

    function void check_sample(stamp_t st, err_t er, stamp_t du, logic fin);
      tie_sample_t want;
      if (awaited_samples.size() == 0) begin
        $error("sample with none awaited: sample_time %0d", st);
        errors++;
      end else begin
        want = awaited_samples.pop_front();
        if (st !== want.sample_time) begin
          $error("sample_time: expected %0d, got %0d", want.sample_time, st);
          errors++;
        end
        if (er !== want.interval_error) begin
          $error("interval_error: expected %0d, got %0d",
                 $signed(want.interval_error), $signed(er));
          errors++;
        end
        if (du !== want.sample_duration) begin
          $error("sample_duration: expected %0d, got %0d", want.sample_duration, du);
          errors++;
        end
        if (fin !== want.is_final) begin
          $error("is_final: expected %0d, got %0d", want.is_final, fin);
          errors++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return awaited_samples.size();
    endfunction
  endclass

endpackage

[tb/sv/tb_time_interval_error_meter_unit.sv]
// Top-level testbench of the time interval error meter: stimulus, idling and final verdict.
`timescale 1ns / 100ps
module tb_time_interval_error_meter_unit;

  typedef tiem_scoreboard_pkg::stamp_t stamp_t;

  localparam int          TB_TIME_BITS  = tiem_pkg::TIME_BITS_DEF;
  localparam logic [1:0]  FUNC_RESERVED = 2'd3;
  localparam int          QUIET_LIMIT   = 4000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          PHASE_ITEMS   = 280;
  localparam stamp_t      T_MAX         = '1;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [TB_TIME_BITS-1:0] cfg_holdoff = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_func = tiem_pkg::FUNC_CLOCK;
  logic [TB_TIME_BITS-1:0] in_edge_time = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [TB_TIME_BITS-1:0] out_sample_time;
  logic [TB_TIME_BITS:0]   out_interval_error;
  logic [TB_TIME_BITS-1:0] out_sample_duration;
  logic                    out_is_final;

  tiem_scoreboard_pkg::tie_scoreboard sb = new();
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   edges_sent = 0;
  int unsigned   hold_requests = 0;
  int unsigned   holds_served = 0;
  int unsigned   quiet_cycles = 0;

  time_interval_error_meter_unit #(.TIME_BITS(TB_TIME_BITS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_holdoff         (cfg_holdoff),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_edge_time        (in_edge_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sample_time     (out_sample_time),
    .out_interval_error  (out_interval_error),
    .out_sample_duration (out_sample_duration),
    .out_is_final        (out_is_final)
  );

  always #2 clk = ~clk;

  function automatic stamp_t rand_stamp();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return stamp_t'(r);
  endfunction

  task automatic send_edge(logic [1:0] func, stamp_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_edge_time <= t;
    do @(posedge clk); while (in_stall);
    sb.apply_edge(func, t);
    if (func != FUNC_RESERVED) edges_sent++;
  endtask

  task automatic wait_idle();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_holdoff(stamp_t value);
    cfg_valid <= 1'b1;
    cfg_holdoff <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_holdoff(value);
  endtask

  task automatic run_capture();
    stamp_t t;
    stamp_t gap;
    stamp_t lo;
    stamp_t off;
    int     n_intervals;
    int     n_clocks;
    if ($urandom_range(3) == 0) t = sb.holdoff - stamp_t'($urandom_range(0, 2000));
    else t = rand_stamp();
    n_intervals = $urandom_range(1, 8);
    send_edge(tiem_pkg::FUNC_GOLDEN, t);
    for (int i = 0; i < n_intervals; i++) begin
      case ($urandom_range(3))
        0: gap = stamp_t'($urandom_range(1, 20));
        1: gap = stamp_t'($urandom_range(21, 5000));
        2: gap = stamp_t'($urandom());
        default: gap = rand_stamp() >> $urandom_range(1, 20);
      endcase
      n_clocks = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
      lo = '0;
      for (int c = 0; c < n_clocks; c++) begin
        case ($urandom_range(9))
          0: off = lo;
          1: off = gap;
          default: off = (gap > lo + 1) ? lo + 1 + rand_stamp() % (gap - lo - 1) : gap;
        endcase
        lo = off;
        send_edge(tiem_pkg::FUNC_CLOCK, t + off);
      end
      t = t + gap;
      send_edge(tiem_pkg::FUNC_GOLDEN, t);
    end
    if ($urandom_range(99) < 85) send_edge(tiem_pkg::FUNC_END, rand_stamp());
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_sample(out_sample_time, out_interval_error, out_sample_duration, out_is_final);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_start;
    bit          hold_asked;
    stamp_t      skip_value;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 31;
    recv_stall_pct = 86;
    send_edge(tiem_pkg::FUNC_CLOCK, stamp_t'(5));
    send_edge(tiem_pkg::FUNC_GOLDEN, stamp_t'(100));
    send_edge(tiem_pkg::FUNC_CLOCK, stamp_t'(100));
    send_edge(tiem_pkg::FUNC_CLOCK, stamp_t'(130));
    send_edge(tiem_pkg::FUNC_CLOCK, stamp_t'(140));
    send_edge(tiem_pkg::FUNC_GOLDEN, stamp_t'(200));
    send_edge(tiem_pkg::FUNC_CLOCK, stamp_t'(260));
    send_edge(tiem_pkg::FUNC_GOLDEN, stamp_t'(301));
    send_edge(tiem_pkg::FUNC_CLOCK, stamp_t'(400));
    send_edge(tiem_pkg::FUNC_GOLDEN, stamp_t'(400));
    send_edge(FUNC_RESERVED, T_MAX);
    send_edge(tiem_pkg::FUNC_END, '0);
    send_edge(tiem_pkg::FUNC_END, T_MAX);
    send_edge(tiem_pkg::FUNC_GOLDEN, '0);
    send_edge(tiem_pkg::FUNC_CLOCK, T_MAX - 1);
    send_edge(tiem_pkg::FUNC_GOLDEN, T_MAX);
    send_edge(tiem_pkg::FUNC_END, '0);
    send_edge(tiem_pkg::FUNC_GOLDEN, stamp_t'(1000));
    send_edge(tiem_pkg::FUNC_CLOCK, stamp_t'(1500));
    send_edge(tiem_pkg::FUNC_GOLDEN, stamp_t'(2000));
    send_edge(tiem_pkg::FUNC_GOLDEN, stamp_t'(10));
    send_edge(tiem_pkg::FUNC_CLOCK, stamp_t'(20));
    send_edge(tiem_pkg::FUNC_GOLDEN, stamp_t'(30));
    send_edge(tiem_pkg::FUNC_END, '0);
    in_valid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: skip_value = rand_stamp();
        1: skip_value = T_MAX;
        2: skip_value = '0;
        3: skip_value = stamp_t'(1) << (TB_TIME_BITS - 1);
        4: skip_value = rand_stamp();
        default: skip_value = '0;
      endcase
      send_idle_pct = (p < 2) ? 31 : (p < 4) ? 86 : 0;
      recv_stall_pct = (p < 2) ? 86 : (p < 4) ? 31 : 0;
      wait_idle();
      write_holdoff(skip_value);
      phase_start = edges_sent;
      hold_asked = 1'b0;
      while (edges_sent - phase_start < PHASE_ITEMS) begin
        if ((p == 2 || p == 4) && !hold_asked && edges_sent - phase_start >= PHASE_ITEMS / 2) begin
          hold_asked = 1'b1;
          hold_requests++;
        end
        if ($urandom_range(9) == 0) send_edge(2'($urandom_range(3)), rand_stamp());
        else run_capture();
      end
      in_valid <= 1'b0;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
